### hdl/indexed_list_engine_defines.svh
// ----------------------------------------------------------------------------
// indexed_list_engine_defines
// Assertion macros shared by the list engine RTL.
// ----------------------------------------------------------------------------
`ifndef INDEXED_LIST_ENGINE_DEFINES_SVH
`define INDEXED_LIST_ENGINE_DEFINES_SVH

`ifndef ASSERT_OFF
`define ILE_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
`define ILE_ASSERT_NEVER(lbl, clk, rstn, cond, msg) \
    `ILE_ASSERT(lbl, clk, rstn, !(cond), msg)
`else
`define ILE_ASSERT(lbl, clk, rstn, prop, msg)
`define ILE_ASSERT_NEVER(lbl, clk, rstn, cond, msg)
`endif

`endif

### hdl/ile_pkg.sv
// ----------------------------------------------------------------------------
// ile_pkg
// Types, codes and helpers of the indexed list engine.
// ----------------------------------------------------------------------------
package ile_pkg;

    localparam int ILE_CAPACITY = 32;
    localparam int POS_W        = 6;    // positions of a list of up to 64 entries
    localparam int CNT_MAX_W    = 7;    // length of a list of up to 64 entries
    localparam int DATA_W       = 32;
    localparam int SUM_W        = 37;
    localparam int MASK_W       = 32;
    localparam int LEN_W        = 6;
    localparam int IDX_W        = 6;
    localparam int OIDX_W       = 5;
    localparam int KIND_W       = 4;
    localparam int STATUS_W     = 2;
    localparam int S_TDATA_W    = 48;
    localparam int M_TDATA_W    = 176;

    typedef enum logic [KIND_W-1:0] {
        REQ_INSERT  = 4'd0,
        REQ_DELETE  = 4'd1,
        REQ_APPEND  = 4'd2,
        REQ_GET     = 4'd3,
        REQ_REPLACE = 4'd4,
        REQ_SWAP    = 4'd5,
        REQ_SEARCH  = 4'd6,
        REQ_REVERSE = 4'd7,
        REQ_ROTL    = 4'd8,
        REQ_ROTR    = 4'd9
    } req_kind_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_RANGE = 2'd1,
        ST_FULL  = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_SWAP,
        S_STATS
    } state_t;

    typedef enum logic [2:0] {
        C_NONE,
        C_INSERT,
        C_DELETE,
        C_WRITE,
        C_SWAP,
        C_ROTL,
        C_ROTR
    } cell_op_t;

    typedef struct packed {
        cell_op_t                 op;
        logic [POS_W-1:0]         pos;
        logic [POS_W-1:0]         pos_b;
        logic [POS_W-1:0]         last;
        logic [CNT_MAX_W-1:0]     count;
        logic [DATA_W-1:0]        wdata;
        logic [DATA_W-1:0]        rdata;
        logic [DATA_W-1:0]        tmp;
    } cell_cmd_t;

    typedef struct packed {
        logic                     valid;
        logic signed [DATA_W-1:0] max;
        logic signed [DATA_W-1:0] min;
        logic signed [SUM_W-1:0]  sum;
    } stat_t;

    function automatic stat_t stat_leaf(input logic [DATA_W-1:0] v, input logic valid);
        stat_t s;
        s = '0;
        if (valid) begin
            s.valid = 1'b1;
            s.max   = v;
            s.min   = v;
            s.sum   = {{(SUM_W-DATA_W){v[DATA_W-1]}}, v};
        end
        return s;
    endfunction

    function automatic stat_t stat_merge(input stat_t a, input stat_t b);
        stat_t s;
        s       = '0;
        s.valid = a.valid | b.valid;
        s.sum   = a.sum + b.sum;
        if (a.valid && b.valid) begin
            s.max = (a.max < b.max) ? b.max : a.max;
            s.min = (b.min < a.min) ? b.min : a.min;
        end else if (a.valid) begin
            s.max = a.max;
            s.min = a.min;
        end else if (b.valid) begin
            s.max = b.max;
            s.min = b.min;
        end
        return s;
    endfunction

endpackage

### hdl/ile_cell.sv
// ----------------------------------------------------------------------------
// ile_cell
// One list position: holds an entry, shifts with its neighbors.
// ----------------------------------------------------------------------------
module ile_cell import ile_pkg::*; #(
    parameter int POS = 0
) (
    input  logic              aclk,
    input  cell_cmd_t         cmd,
    input  logic [POS_W-1:0]  rd_pos,
    input  logic [DATA_W-1:0] left_val,
    input  logic [DATA_W-1:0] right_val,
    output logic [DATA_W-1:0] value,
    output logic [DATA_W-1:0] rd_val,
    output logic              hit
);

    localparam logic [POS_W-1:0]     P  = POS_W'(POS);
    localparam logic [CNT_MAX_W-1:0] PC = CNT_MAX_W'(POS);

    logic [DATA_W-1:0] value_reg;
    logic [DATA_W-1:0] value_next;

    always_comb begin
        value_next = value_reg;
        case (cmd.op)
            C_INSERT: begin
                if (P > cmd.pos) begin
                    value_next = left_val;
                end else if (P == cmd.pos) begin
                    value_next = cmd.wdata;
                end
            end
            C_DELETE: begin
                if (P >= cmd.pos) begin
                    value_next = right_val;
                end
            end
            C_WRITE: begin
                if (P == cmd.pos) begin
                    value_next = cmd.wdata;
                end
            end
            C_SWAP: begin
                if (P == cmd.pos) begin
                    value_next = cmd.rdata;
                end else if (P == cmd.pos_b) begin
                    value_next = cmd.tmp;
                end
            end
            C_ROTL: begin
                if (P < cmd.last) begin
                    value_next = right_val;
                end else if (P == cmd.last) begin
                    value_next = cmd.rdata;
                end
            end
            C_ROTR: begin
                if (P == '0) begin
                    value_next = cmd.rdata;
                end else if (P <= cmd.last) begin
                    value_next = left_val;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        value_reg <= value_next;
    end

    assign value  = value_reg;
    assign rd_val = (rd_pos == P) ? value_reg : '0;
    assign hit    = (value_reg == cmd.wdata) && (PC < cmd.count);

endmodule

### hdl/ile_stat_tree.sv
// ----------------------------------------------------------------------------
// ile_stat_tree
// Registered reduction tree for max, min and sum of the valid entries.
// ----------------------------------------------------------------------------
module ile_stat_tree import ile_pkg::*; #(
    parameter int CAPACITY = ILE_CAPACITY
) (
    input  logic                 aclk,
    input  logic [DATA_W-1:0]    values [CAPACITY],
    input  logic [CNT_MAX_W-1:0] count,
    output stat_t                root
);

    localparam int LEVELS = $clog2(CAPACITY);
    localparam int LEAVES = 1 << LEVELS;

    stat_t leaf     [LEAVES];
    stat_t tree_n   [1:2*LEAVES-1];
    stat_t node_reg [1:LEAVES-1];

    always_comb begin
        for (int j = 0; j < LEAVES; j++) begin
            if (j < CAPACITY) begin
                leaf[j] = stat_leaf(values[j], CNT_MAX_W'(j) < count);
            end else begin
                leaf[j] = '0;
            end
        end
    end

    always_comb begin
        for (int n = 1; n < 2*LEAVES; n++) begin
            if (n >= LEAVES) begin
                tree_n[n] = leaf[n-LEAVES];
            end else begin
                tree_n[n] = node_reg[n];
            end
        end
    end

    always_ff @(posedge aclk) begin
        for (int n = 1; n < LEAVES; n++) begin
            node_reg[n] <= stat_merge(tree_n[2*n], tree_n[2*n+1]);
        end
    end

    assign root = tree_n[1];

endmodule

### hdl/indexed_list_engine.sv
// ----------------------------------------------------------------------------
// indexed_list_engine
// Packed list of signed words with insert, delete, rotate, search and stats.
// ----------------------------------------------------------------------------
// Usage:
//   s_ channel carries one request per item: s_tuser is the request kind,
//   s_tdata holds index, other_index and value. m_ channel returns one result
//   per request: m_tuser is the status, m_tdata the read value, search mask,
//   length, max, min and sum after the request.
//   The entries sit in a row of cells, one per position; shifts and rotations
//   move each affected cell by one position together, reads go over a shared
//   read bus. Stats come from a registered tree of ceil(log2(CAPACITY)) levels.
//   Swap and reverse add exchange steps; reverse exchanges one pair at a time
//   over the single read bus port. One request is worked at a time; the next is
//   taken in the cycle after the result is loaded, also while that result waits.
//   If m_tready is low the result is held and the following request stops
//   before loading its result. Reset empties the list and holds s_tready low;
//   no clearing pass.
// ----------------------------------------------------------------------------
`include "indexed_list_engine_defines.svh"

module indexed_list_engine import ile_pkg::*; #(
    parameter int CAPACITY = ILE_CAPACITY
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    // index[5:0], other_index[10:6], value[42:11], zero pad
    input  logic [S_TDATA_W-1:0] s_tdata,
    // req_type[3:0]
    input  logic [KIND_W-1:0]    s_tuser,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    // read_value[31:0], match_mask[63:32], list_length[69:64], max_value[101:70],
    // min_value[133:102], sum_value[170:134], zero pad
    output logic [M_TDATA_W-1:0] m_tdata,
    // status[1:0]
    output logic [STATUS_W-1:0]  m_tuser
);

    localparam int LEVELS = $clog2(CAPACITY);
    localparam int WAIT_W = $clog2(LEVELS + 1);
    localparam int CNT_W  = $clog2(CAPACITY + 1);
    localparam int CW     = (CNT_W > POS_W) ? CNT_W : POS_W;

    state_t               state_reg, state_next;
    logic [CNT_W-1:0]     count_reg, count_next;
    logic                 m_valid_reg, m_valid_next;
    req_kind_t            kind_reg, kind_next;
    logic [IDX_W-1:0]     idx_reg, idx_next;
    logic [OIDX_W-1:0]    oidx_reg, oidx_next;
    logic [DATA_W-1:0]    val_reg, val_next;
    logic [POS_W-1:0]     lo_reg, lo_next;
    logic [POS_W-1:0]     hi_reg, hi_next;
    logic [DATA_W-1:0]    tmp_reg, tmp_next;
    logic [WAIT_W-1:0]    wait_reg, wait_next;
    status_t              res_status_reg, res_status_next;
    logic [DATA_W-1:0]    res_read_reg, res_read_next;
    logic [MASK_W-1:0]    res_mask_reg, res_mask_next;
    logic [STATUS_W-1:0]  m_user_reg, m_user_next;
    logic [M_TDATA_W-1:0] m_data_reg, m_data_next;

    cell_cmd_t            cmd;
    logic [POS_W-1:0]     rd_pos;
    logic [POS_W-1:0]     last_pos;
    logic [DATA_W-1:0]    rd_bus;
    logic [DATA_W-1:0]    cell_val [CAPACITY];
    logic [DATA_W-1:0]    cell_rd  [CAPACITY];
    logic [CAPACITY-1:0]  cell_hit;
    logic [MASK_W-1:0]    hit_mask;
    stat_t                root;

    logic [CW-1:0]        idx_x, oidx_x, cnt_x, cap_x;

    assign idx_x    = CW'(idx_reg);
    assign oidx_x   = CW'(oidx_reg);
    assign cnt_x    = CW'(count_reg);
    assign cap_x    = CW'(CAPACITY);
    assign last_pos = POS_W'(count_reg - 1'b1);

    // ---- cell row ----
    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        logic [DATA_W-1:0] left_v, right_v;
        if (g == 0) begin : g_first
            assign left_v = cell_val[g];
        end else begin : g_mid_l
            assign left_v = cell_val[g-1];
        end
        if (g == CAPACITY - 1) begin : g_last
            assign right_v = cell_val[g];
        end else begin : g_mid_r
            assign right_v = cell_val[g+1];
        end
        ile_cell #(
            .POS(g)
        ) u_cell (
            .aclk      (aclk),
            .cmd       (cmd),
            .rd_pos    (rd_pos),
            .left_val  (left_v),
            .right_val (right_v),
            .value     (cell_val[g]),
            .rd_val    (cell_rd[g]),
            .hit       (cell_hit[g])
        );
    end

    always_comb begin
        rd_bus = '0;
        for (int i = 0; i < CAPACITY; i++) begin
            rd_bus = rd_bus | cell_rd[i];
        end
    end

    for (genvar g = 0; g < MASK_W; g++) begin : g_mask
        if (g < CAPACITY) begin : g_on
            assign hit_mask[g] = cell_hit[g];
        end else begin : g_off
            assign hit_mask[g] = 1'b0;
        end
    end

    ile_stat_tree #(
        .CAPACITY(CAPACITY)
    ) u_stats (
        .aclk   (aclk),
        .values (cell_val),
        .count  (CNT_MAX_W'(count_reg)),
        .root   (root)
    );

    // ---- read bus address ----
    always_comb begin
        rd_pos = POS_W'(idx_reg);
        if (state_reg == S_SWAP) begin
            rd_pos = (kind_reg == REQ_REVERSE) ? hi_reg : POS_W'(oidx_reg);
        end else begin
            case (kind_reg)
                REQ_REVERSE: rd_pos = lo_reg;
                REQ_ROTL:    rd_pos = '0;
                REQ_ROTR:    rd_pos = last_pos;
                default:     rd_pos = POS_W'(idx_reg);
            endcase
        end
    end

    // ---- control ----
    always_comb begin
        state_next      = state_reg;
        count_next      = count_reg;
        m_valid_next    = m_valid_reg;
        kind_next       = kind_reg;
        idx_next        = idx_reg;
        oidx_next       = oidx_reg;
        val_next        = val_reg;
        lo_next         = lo_reg;
        hi_next         = hi_reg;
        tmp_next        = tmp_reg;
        wait_next       = wait_reg;
        res_status_next = res_status_reg;
        res_read_next   = res_read_reg;
        res_mask_next   = res_mask_reg;
        m_user_next     = m_user_reg;
        m_data_next     = m_data_reg;
        s_tready        = 1'b0;

        cmd       = '0;
        cmd.op    = C_NONE;
        cmd.pos   = POS_W'(idx_reg);
        cmd.pos_b = POS_W'(oidx_reg);
        cmd.last  = last_pos;
        cmd.count = CNT_MAX_W'(count_reg);
        cmd.wdata = val_reg;
        cmd.rdata = rd_bus;
        cmd.tmp   = tmp_reg;

        if (m_valid_reg && m_tready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE: begin
                s_tready = aresetn;
                if (s_tvalid) begin
                    kind_next  = req_kind_t'(s_tuser);
                    idx_next   = s_tdata[5:0];
                    oidx_next  = s_tdata[10:6];
                    val_next   = s_tdata[42:11];
                    lo_next    = '0;
                    hi_next    = (count_reg == '0) ? '0 : last_pos;
                    state_next = S_EXEC;
                end
            end
            S_EXEC: begin
                res_status_next = ST_OK;
                res_read_next   = '0;
                res_mask_next   = '0;
                state_next      = S_STATS;
                wait_next       = '0;
                case (kind_reg)
                    REQ_INSERT: begin
                        if (idx_x > cnt_x) begin
                            res_status_next = ST_RANGE;
                        end else if (cnt_x >= cap_x) begin
                            res_status_next = ST_FULL;
                        end else begin
                            cmd.op     = C_INSERT;
                            count_next = count_reg + 1'b1;
                        end
                    end
                    REQ_DELETE: begin
                        if (idx_x >= cnt_x) begin
                            res_status_next = ST_RANGE;
                        end else begin
                            res_read_next = rd_bus;
                            cmd.op        = C_DELETE;
                            count_next    = count_reg - 1'b1;
                        end
                    end
                    REQ_APPEND: begin
                        if (cnt_x >= cap_x) begin
                            res_status_next = ST_FULL;
                        end else begin
                            cmd.op     = C_WRITE;
                            cmd.pos    = POS_W'(count_reg);
                            count_next = count_reg + 1'b1;
                        end
                    end
                    REQ_GET: begin
                        if (idx_x >= cnt_x) begin
                            res_status_next = ST_RANGE;
                        end else begin
                            res_read_next = rd_bus;
                        end
                    end
                    REQ_REPLACE: begin
                        if (idx_x >= cnt_x) begin
                            res_status_next = ST_RANGE;
                        end else begin
                            cmd.op = C_WRITE;
                        end
                    end
                    REQ_SWAP: begin
                        if (idx_x >= cnt_x || oidx_x >= cnt_x) begin
                            res_status_next = ST_RANGE;
                        end else begin
                            tmp_next   = rd_bus;
                            state_next = S_SWAP;
                        end
                    end
                    REQ_SEARCH: begin
                        res_mask_next = hit_mask;
                    end
                    REQ_REVERSE: begin
                        if (lo_reg < hi_reg) begin
                            tmp_next   = rd_bus;
                            state_next = S_SWAP;
                        end
                    end
                    REQ_ROTL: begin
                        if (cnt_x > CW'(1)) begin
                            cmd.op = C_ROTL;
                        end
                    end
                    REQ_ROTR: begin
                        if (cnt_x > CW'(1)) begin
                            cmd.op = C_ROTR;
                        end
                    end
                    default: begin
                    end
                endcase
            end
            S_SWAP: begin
                cmd.op = C_SWAP;
                if (kind_reg == REQ_REVERSE) begin
                    cmd.pos    = lo_reg;
                    cmd.pos_b  = hi_reg;
                    lo_next    = POS_W'(lo_reg + 1'b1);
                    hi_next    = POS_W'(hi_reg - 1'b1);
                    state_next = S_EXEC;
                end else begin
                    state_next = S_STATS;
                    wait_next  = '0;
                end
            end
            S_STATS: begin
                if (wait_reg == WAIT_W'(LEVELS)) begin
                    if (!m_valid_reg || m_tready) begin
                        m_valid_next = 1'b1;
                        m_user_next  = res_status_reg;
                        m_data_next  = {{(M_TDATA_W - SUM_W - 3*DATA_W - LEN_W - MASK_W){1'b0}},
                                        root.sum, root.min, root.max,
                                        LEN_W'(count_reg), res_mask_reg, res_read_reg};
                        state_next   = S_IDLE;
                    end
                end else begin
                    wait_next = WAIT_W'(wait_reg + 1'b1);
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        kind_reg       <= kind_next;
        idx_reg        <= idx_next;
        oidx_reg       <= oidx_next;
        val_reg        <= val_next;
        lo_reg         <= lo_next;
        hi_reg         <= hi_next;
        tmp_reg        <= tmp_next;
        wait_reg       <= wait_next;
        res_status_reg <= res_status_next;
        res_read_reg   <= res_read_next;
        res_mask_reg   <= res_mask_next;
        m_user_reg     <= m_user_next;
        m_data_reg     <= m_data_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_user_reg;

    // ---- checks ----
    `ILE_ASSERT_NEVER(a_count_cap, aclk, aresetn, cnt_x > cap_x, "list length above capacity")
    `ILE_ASSERT(a_count_only_exec, aclk, aresetn, (state_reg != S_EXEC) |=> $stable(count_reg), "length changed outside execute")
    `ILE_ASSERT(a_swap_kind, aclk, aresetn, (state_reg == S_SWAP) |-> (kind_reg == REQ_SWAP || kind_reg == REQ_REVERSE), "exchange step for wrong kind")
    `ILE_ASSERT(a_rev_order, aclk, aresetn, (state_reg == S_SWAP && kind_reg == REQ_REVERSE) |-> (lo_reg < hi_reg), "reverse pointers crossed")

endmodule
